// File: rtl/sl2_pkg.sv
// Shared codes and control types for the SL(2,Z/p) relator checker.
// No dependencies.
`default_nettype none
package sl2_pkg;

  localparam logic [1:0] ST_LOAD_OK  = 2'd0;
  localparam logic [1:0] ST_LOAD_BAD = 2'd1;
  localparam logic [1:0] ST_VERDICT  = 2'd2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LETTER = 1'b1;

  localparam logic CFG_MODULUS    = 1'b0;
  localparam logic CFG_PROJECTIVE = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam int FIELD_W    = 16;

  typedef struct packed {
    logic start;
    logic bypass;   // modulus below two: result is forced to zero
  } mm_ctl_t;

endpackage
`default_nettype wire

// File: rtl/sl2_if.sv
// Valid/ready channel interfaces: input items, results, register writes.
// Depends on sl2_pkg.
`default_nettype none
interface sl2_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [3:0]                   gen_slot;
  logic [sl2_pkg::FIELD_W-1:0]  entry_a;
  logic [sl2_pkg::FIELD_W-1:0]  entry_b;
  logic [sl2_pkg::FIELD_W-1:0]  entry_c;
  logic [sl2_pkg::FIELD_W-1:0]  entry_d;
  logic [3:0]                   letter_gen;
  logic                         letter_inverse;
  logic                         relator_end;
  logic                         presentation_end;
  modport source (output valid, req_type, gen_slot, entry_a, entry_b, entry_c, entry_d,
                  letter_gen, letter_inverse, relator_end, presentation_end,
                  input ready);
  modport sink (input valid, req_type, gen_slot, entry_a, entry_b, entry_c, entry_d,
                letter_gen, letter_inverse, relator_end, presentation_end,
                output ready);
endinterface

interface sl2_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       relator_holds;
  logic       all_hold;
  logic       last;
  modport source (output valid, status, relator_holds, all_hold, last, input ready);
  modport sink (input valid, status, relator_holds, all_hold, last, output ready);
endinterface

interface sl2_cfg_if;
  logic                            valid;
  logic                            ready;
  logic                            index;
  logic [sl2_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/sl2_mod_p_relator_check.sv
// Top level of the SL(2,Z/p) relator checker: generator store, product, verdicts.
// Depends on sl2_pkg, sl2_if (channel interfaces) and sl2_modmul (eight lanes).
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | req_type, gen_slot, entry_a..d, letter fields
//  out_ch   | out | valid/ready   | status, relator_holds, all_hold, last
//  cfg_ch   | in  | valid/ready   | index (0 modulus, 1 projective_mode), data
//
// One item at a time, paced by the bit-serial modular multipliers (eight run side by
// side, one bit per cycle). A letter that ends no relator returns no result; a load
// or a verdict gives one result on out_ch. A result waits in the output register;
// the next item is taken once it is gone.
// Reset (rst_n low, synchronous) clears control, the product and the flags;
// the generator store has no reset. cfg_ch is always ready.
`default_nettype none
module sl2_mod_p_relator_check #(
  parameter int NUM_GENERATORS = 16,
  parameter int ENTRY_WIDTH    = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sl2_in_if.sink    in_ch,
  sl2_out_if.source out_ch,
  sl2_cfg_if.sink   cfg_ch
);
  localparam int EW = (ENTRY_WIDTH < sl2_pkg::FIELD_W) ? ENTRY_WIDTH : sl2_pkg::FIELD_W;
  localparam int AW = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
  localparam int NL = 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_VER  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [15:0]   mod_r;
  logic          proj_r;
  logic [EW-1:0] p;
  logic          p_ok;

  // captured item
  logic          typ_r, linv_r, rend_r, pend_r;
  logic [3:0]    slot_r, lgen_r;
  logic [EW-1:0] ea_r, eb_r, ec_r, ed_r;

  logic [EW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic          pres_ok_r;
  logic          start_r;

  logic [1:0]    ost_r;
  logic          ohold_r, oall_r, olast_r;

  logic [8*EW-1:0] mem [NUM_GENERATORS];
  logic [8*EW-1:0] rd_q_r;
  logic [AW+3:0]   rd_ext, wr_ext;

  logic [EW-1:0] lx [NL];
  logic [EW-1:0] ly [NL];
  logic [EW-1:0] lres [NL];
  logic          ldone [NL];
  sl2_pkg::mm_ctl_t mctl;

  logic [EW-1:0] r0, r1, r2, r3;
  logic          gslot_ok, lslot_ok;
  logic [EW-1:0] n0, n1, n2, n3, det;
  logic          load_ok, holds, all_ok;
  logic          in_acc;

  function automatic logic [EW-1:0] add_mod(input logic [EW-1:0] u, input logic [EW-1:0] v,
                                            input logic [EW-1:0] m);
    logic [EW:0] sm;
    sm = {1'b0, u} + {1'b0, v};
    return (sm >= {1'b0, m}) ? EW'(sm - {1'b0, m}) : EW'(sm);
  endfunction

  assign p        = mod_r[EW-1:0];
  assign p_ok     = p >= EW'(2);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign gslot_ok = int'(slot_r) < NUM_GENERATORS;
  assign lslot_ok = int'(lgen_r) < NUM_GENERATORS;

  assign rd_ext = {{AW{1'b0}}, in_ch.letter_gen};
  assign wr_ext = {{AW{1'b0}}, slot_r};

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_ext[AW-1:0]];
    if (state_r == S_FIN && typ_r == sl2_pkg::REQ_LOAD && load_ok) begin
      mem[wr_ext[AW-1:0]] <= {ea_r, eb_r, ec_r, ed_r,
                              ed_r, (eb_r == '0) ? EW'(0) : EW'(p - eb_r),
                              (ec_r == '0) ? EW'(0) : EW'(p - ec_r), ea_r};
    end
  end

  // right-hand operand of the letter: generator, inverse or zero
  always_comb begin
    {r0, r1, r2, r3} = linv_r ? rd_q_r[4*EW-1:0] : rd_q_r[8*EW-1:4*EW];
    if (!lslot_ok) begin
      {r0, r1, r2, r3} = '0;
    end
  end

  always_comb begin
    if (typ_r == sl2_pkg::REQ_LOAD) begin
      lx[0] = ea_r; ly[0] = ed_r;
      lx[1] = eb_r; ly[1] = ec_r;
      for (int i = 2; i < NL; i++) begin
        lx[i] = '0; ly[i] = '0;
      end
    end else begin
      lx[0] = pa_r; ly[0] = r0;
      lx[1] = pb_r; ly[1] = r2;
      lx[2] = pa_r; ly[2] = r1;
      lx[3] = pb_r; ly[3] = r3;
      lx[4] = pc_r; ly[4] = r0;
      lx[5] = pd_r; ly[5] = r2;
      lx[6] = pc_r; ly[6] = r1;
      lx[7] = pd_r; ly[7] = r3;
    end
  end

  assign mctl.start  = start_r;
  assign mctl.bypass = !p_ok;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    sl2_modmul #(.W(EW)) u_mm (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (mctl),
      .x    (lx[g]),
      .y    (ly[g]),
      .p    (p),
      .done (ldone[g]),
      .res  (lres[g])
    );
  end

  assign n0  = p_ok ? add_mod(lres[0], lres[1], p) : '0;
  assign n1  = p_ok ? add_mod(lres[2], lres[3], p) : '0;
  assign n2  = p_ok ? add_mod(lres[4], lres[5], p) : '0;
  assign n3  = p_ok ? add_mod(lres[6], lres[7], p) : '0;
  assign det = (lres[0] >= lres[1]) ? EW'(lres[0] - lres[1])
                                    : EW'({1'b0, lres[0]} + {1'b0, p} - {1'b0, lres[1]});
  assign load_ok = p_ok && gslot_ok && ea_r < p && eb_r < p && ec_r < p && ed_r < p &&
                   det == EW'(1);
  assign holds = pb_r == '0 && pc_r == '0 && pa_r == pd_r &&
                 (pa_r == EW'(1) || (proj_r && p_ok && pa_r == EW'(p - EW'(1))));
  assign all_ok = pres_ok_r && holds;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MUL;
      S_MUL:  if (ldone[0]) state_nxt = S_FIN;
      S_FIN: begin
        if (typ_r == sl2_pkg::REQ_LOAD) state_nxt = S_HOLD;
        else if (rend_r) state_nxt = S_VER;
        else state_nxt = S_IDLE;
      end
      S_VER:  state_nxt = S_HOLD;
      S_HOLD: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b0;
      mod_r     <= 16'd2;
      proj_r    <= 1'b0;
      pa_r      <= EW'(1);
      pb_r      <= '0;
      pc_r      <= '0;
      pd_r      <= EW'(1);
      pres_ok_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == sl2_pkg::CFG_MODULUS) mod_r <= cfg_ch.data;
        else proj_r <= cfg_ch.data[0];
      end
      if (state_r == S_FIN && typ_r == sl2_pkg::REQ_LETTER) begin
        pa_r <= n0; pb_r <= n1; pc_r <= n2; pd_r <= n3;
      end
      if (state_r == S_VER) begin
        pa_r <= EW'(1); pb_r <= '0; pc_r <= '0; pd_r <= EW'(1);
        pres_ok_r <= pend_r ? 1'b1 : all_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      typ_r  <= in_ch.req_type;
      slot_r <= in_ch.gen_slot;
      ea_r   <= in_ch.entry_a[EW-1:0];
      eb_r   <= in_ch.entry_b[EW-1:0];
      ec_r   <= in_ch.entry_c[EW-1:0];
      ed_r   <= in_ch.entry_d[EW-1:0];
      lgen_r <= in_ch.letter_gen;
      linv_r <= in_ch.letter_inverse;
      rend_r <= in_ch.relator_end;
      pend_r <= in_ch.presentation_end;
    end
    if (state_r == S_FIN && typ_r == sl2_pkg::REQ_LOAD) begin
      ost_r   <= load_ok ? sl2_pkg::ST_LOAD_OK : sl2_pkg::ST_LOAD_BAD;
      ohold_r <= 1'b0;
      oall_r  <= 1'b0;
      olast_r <= 1'b0;
    end
    if (state_r == S_VER) begin
      ost_r   <= sl2_pkg::ST_VERDICT;
      ohold_r <= holds;
      oall_r  <= all_ok;
      olast_r <= pend_r;
    end
  end

  assign out_ch.valid         = (state_r == S_HOLD);
  assign out_ch.status        = ost_r;
  assign out_ch.relator_holds = ohold_r;
  assign out_ch.all_hold      = oall_r;
  assign out_ch.last          = olast_r;

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready && start_r)
    else $error("item accepted but multiply not started");

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ldone[0] |-> state_r == S_MUL)
    else $error("multiplier finished outside multiply phase");

  a_ver_ident: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VER |=> pa_r == EW'(1) && pb_r == '0 && pc_r == '0 && pd_r == EW'(1))
    else $error("product not restarted after verdict");

  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    ldone[0] |-> ldone[NL-1])
    else $error("multiplier lanes out of step");
endmodule
`default_nettype wire

// File: rtl/sl2_modmul.sv
// Bit-serial modular multiplier: res = (x * y) mod p in 2*W steps, or zero when bypassed.
// First W steps reduce x mod p, next W steps shift-add over y. Uses sl2_pkg.
`default_nettype none
module sl2_modmul #(
  parameter int W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sl2_pkg::mm_ctl_t ctl,
  input  wire logic [W-1:0]     x,
  input  wire logic [W-1:0]     y,
  input  wire logic [W-1:0]     p,
  output logic                  done,
  output logic [W-1:0]          res
);
  localparam int CW = $clog2(2 * W + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(2 * W - 1);
  localparam logic [CW-1:0] HALF      = CW'(W);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          byp_r, byp_nxt;
  logic [W-1:0]  xs_r, xs_nxt, ys_r, ys_nxt, rx_r, rx_nxt, acc_r, acc_nxt;
  logic [W:0]    t, d, d2, s, pe;

  always_comb begin
    pe       = {1'b0, p};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    byp_nxt  = byp_r;
    xs_nxt   = xs_r;
    ys_nxt   = ys_r;
    rx_nxt   = rx_r;
    acc_nxt  = acc_r;
    t  = {rx_r, xs_r[W-1]};
    d  = {acc_r, 1'b0};
    d2 = (d >= pe) ? d - pe : d;
    s  = d2 + (ys_r[W-1] ? {1'b0, rx_r} : '0);
    if (ctl.start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      byp_nxt  = ctl.bypass;
      xs_nxt   = x;
      ys_nxt   = y;
      rx_nxt   = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r < HALF) begin
        rx_nxt = (t >= pe) ? W'(t - pe) : W'(t);
        xs_nxt = {xs_r[W-2:0], 1'b0};
      end else begin
        acc_nxt = (s >= pe) ? W'(s - pe) : W'(s);
        ys_nxt  = {ys_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    byp_r <= byp_nxt;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    rx_r  <= rx_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = byp_r ? '0 : acc_r;
endmodule
`default_nettype wire

// File: verif/sl2_mod_p_relator_check_tb.sv
// Self-checking testbench for the SL(2,Z/p) relator checker: matrix loads, word letters, verdicts.
// Drives random and directed beats; checks results against a matrix predictor or listed values.
// Depends on sl2_pkg, the sl2_if channel interfaces and the sl2_mod_p_relator_check top level.
`default_nettype none
module sl2_mod_p_relator_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGEN = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        req_type;
    logic [3:0]  gen_slot;
    logic [15:0] ea, eb, ec, ed;
    logic [3:0]  letter_gen;
    logic        inv, rel_end, pres_end;
  } req_t;

  typedef struct {
    logic [1:0] status;
    logic       holds;
    logic       all_ok;
    logic       last;
  } verdict_t;

  typedef struct {
    req_t     r;
    bit       typed;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sl2_in_if  in_ch();
  sl2_out_if out_ch();
  sl2_cfg_if cfg_ch();

  sl2_mod_p_relator_check DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  longint unsigned gen_m[NGEN][4];
  longint unsigned inv_m[NGEN][4];
  longint unsigned prod[4];
  bit              pres_ok;
  bit              loaded[NGEN];
  logic [15:0]     mod_r;
  bit              proj_r;

  verdict_t verdict_q[$];
  int       fails = 0;
  int       idle_pct = 14;
  longint   cycles = 0;

  function automatic longint unsigned red(longint unsigned x);
    if (mod_r == 0) return 0;
    return x % mod_r;
  endfunction

  // Applies one accepted beat to the model state; returns 1 when a result is due.
  function automatic bit predict(input req_t r, output verdict_t v);
    longint unsigned p, det, a, b, c, d;
    longint unsigned m[4];
    bit ok, holds;
    p = mod_r;
    v = '{status: sl2_pkg::ST_LOAD_OK, holds: 1'b0, all_ok: 1'b0, last: 1'b0};
    if (r.req_type == sl2_pkg::REQ_LOAD) begin
      a = r.ea; b = r.eb; c = r.ec; d = r.ed;
      ok = p >= 2 && a < p && b < p && c < p && d < p;
      if (ok) begin
        det = red(red(a * d) + p - red(b * c));
        ok = det == 1;
      end
      if (ok) begin
        gen_m[r.gen_slot] = '{a, b, c, d};
        inv_m[r.gen_slot] = '{d, red(p - b), red(p - c), a};
        loaded[r.gen_slot] = 1'b1;
      end
      v.status = ok ? sl2_pkg::ST_LOAD_OK : sl2_pkg::ST_LOAD_BAD;
      return 1'b1;
    end
    if (r.inv) m = inv_m[r.letter_gen];
    else m = gen_m[r.letter_gen];
    a = prod[0]; b = prod[1]; c = prod[2]; d = prod[3];
    prod[0] = red(red(a * m[0]) + red(b * m[2]));
    prod[1] = red(red(a * m[1]) + red(b * m[3]));
    prod[2] = red(red(c * m[0]) + red(d * m[2]));
    prod[3] = red(red(c * m[1]) + red(d * m[3]));
    if (!r.rel_end) return 1'b0;
    holds = prod[1] == 0 && prod[2] == 0 && prod[0] == prod[3] &&
            (prod[0] == 1 || (proj_r && p >= 2 && prod[0] == p - 1));
    v.status = sl2_pkg::ST_VERDICT;
    v.holds  = holds;
    v.all_ok = pres_ok && holds;
    v.last   = r.pres_end;
    prod = '{1, 0, 0, 1};
    pres_ok = r.pres_end ? 1'b1 : v.all_ok;
    return 1'b1;
  endfunction

  function automatic req_t mk_load(input int slot, input longint unsigned a, b, c, d);
    req_t r;
    r.req_type = sl2_pkg::REQ_LOAD; r.gen_slot = 4'(slot);
    r.ea = 16'(a); r.eb = 16'(b); r.ec = 16'(c); r.ed = 16'(d);
    r.letter_gen = 4'($urandom); r.inv = 1'($urandom);
    r.rel_end = 1'($urandom); r.pres_end = 1'($urandom);
    return r;
  endfunction

  function automatic req_t mk_letter(input int g, input bit inv, re, pe);
    req_t r;
    r.req_type = sl2_pkg::REQ_LETTER; r.gen_slot = 4'($urandom);
    r.ea = 16'($urandom); r.eb = 16'($urandom); r.ec = 16'($urandom); r.ed = 16'($urandom);
    r.letter_gen = 4'(g); r.inv = inv; r.rel_end = re; r.pres_end = pe;
    return r;
  endfunction

  // determinant-one matrix in one of a few shapes
  function automatic req_t mk_good_load(input int slot);
    longint unsigned p, b, c, bc1;
    p = mod_r;
    b = $urandom_range(32'(p - 1));
    c = $urandom_range(32'(p - 1));
    bc1 = (1 + b * c) % p;
    case ($urandom_range(9))
      0:       return mk_load(slot, p - 1, 0, 0, p - 1);
      1:       return mk_load(slot, 0, p - 1, 1, 0);
      2, 3, 4: return mk_load(slot, bc1, b, c, 1);
      default: return mk_load(slot, 1, b, c, bc1);
    endcase
  endfunction

  task automatic send(input req_t r, input bit typed = 1'b0, input verdict_t tv = '{0, 0, 0, 0});
    verdict_t v;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.req_type;
    in_ch.gen_slot <= r.gen_slot;
    in_ch.entry_a <= r.ea;
    in_ch.entry_b <= r.eb;
    in_ch.entry_c <= r.ec;
    in_ch.entry_d <= r.ed;
    in_ch.letter_gen <= r.letter_gen;
    in_ch.letter_inverse <= r.inv;
    in_ch.relator_end <= r.rel_end;
    in_ch.presentation_end <= r.pres_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict(r, v)) begin
      if (typed) verdict_q.push_back(tv);
      else verdict_q.push_back(v);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] m, input bit pm);
    drain();
    // letters that end no relator may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= sl2_pkg::CFG_MODULUS; cfg_ch.data <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    mod_r = m;
    @(negedge clk);
    cfg_ch.index <= sl2_pkg::CFG_PROJECTIVE; cfg_ch.data <= {15'h0, pm};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    proj_r = pm;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int pick_slot();
    int s;
    do s = $urandom_range(NGEN - 1); while (!loaded[s]);
    return s;
  endfunction

  // One presentation: mostly words followed by their inverse, some random words.
  task automatic run_presentation(inout int n);
    int nrel, len, gs[$];
    bit is[$];
    bit pe;
    nrel = $urandom_range(1, 3);
    for (int k = 0; k < nrel; k++) begin
      gs.delete(); is.delete();
      len = $urandom_range(1, 3);
      for (int j = 0; j < len; j++) begin
        gs.push_back(pick_slot()); is.push_back(1'($urandom));
      end
      if ($urandom_range(99) < 70) begin
        for (int j = len - 1; j >= 0; j--) begin
          gs.push_back(gs[j]); is.push_back(!is[j]);
        end
      end
      for (int j = 0; j < gs.size(); j++) begin
        if (j == gs.size() - 1) pe = k == nrel - 1;
        else pe = $urandom_range(99) < 5;
        send(mk_letter(gs[j], is[j], j == gs.size() - 1, pe));
        n++;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] m, input bit pm, input int items);
    int n;
    int r;
    bit paused;
    n = 0;
    paused = 1'b0;
    set_config(m, pm);
    if (m >= 2)
      for (int s = 0; s < NGEN; s++) begin
        send(mk_good_load(s)); n++;
      end
    while (n < items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send(mk_load($urandom_range(NGEN - 1), $urandom_range(65534), $urandom_range(65534),
                     $urandom_range(65534), $urandom_range(65534)));
        n++;
      end else if (r < 14 && m >= 2) begin
        send(mk_good_load($urandom_range(NGEN - 1))); n++;
      end else begin
        run_presentation(n);
      end
      if (!paused && n > items / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result beat: status %0d", out_ch.status);
        fails++;
      end else begin
        e = verdict_q.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_ch.status); fails++;
        end
        if (out_ch.relator_holds !== e.holds) begin
          $error("relator_holds: expected %0d actual %0d", e.holds, out_ch.relator_holds);
          fails++;
        end
        if (out_ch.all_hold !== e.all_ok) begin
          $error("all_hold: expected %0d actual %0d", e.all_ok, out_ch.all_hold); fails++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_ch.last); fails++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= $urandom_range(99) >= idle_pct;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    in_ch.valid = 1'b0;
    in_ch.req_type = sl2_pkg::REQ_LOAD;
    in_ch.gen_slot = '0;
    in_ch.entry_a = '0;
    in_ch.entry_b = '0;
    in_ch.entry_c = '0;
    in_ch.entry_d = '0;
    in_ch.letter_gen = '0;
    in_ch.letter_inverse = 1'b0;
    in_ch.relator_end = 1'b0;
    in_ch.presentation_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = sl2_pkg::CFG_MODULUS;
    cfg_ch.data = '0;
    mod_r = 16'd2;
    proj_r = 1'b0;
    prod = '{1, 0, 0, 1};
    pres_ok = 1'b1;
    foreach (loaded[s]) loaded[s] = 1'b0;
    foreach (gen_m[s]) begin
      gen_m[s] = '{0, 0, 0, 0};
      inv_m[s] = '{0, 0, 0, 0};
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings: modulus 2, identity only
    rows.push_back('{mk_load(0, 1, 0, 0, 1), 1, '{sl2_pkg::ST_LOAD_OK, 0, 0, 0}});
    rows.push_back('{mk_load(15, 1, 1, 0, 1), 1, '{sl2_pkg::ST_LOAD_OK, 0, 0, 0}});
    rows.push_back('{mk_load(1, 0, 1, 1, 0), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk_load(2, 2, 0, 0, 1), 1, '{sl2_pkg::ST_LOAD_BAD, 0, 0, 0}});
    rows.push_back('{mk_load(3, 65534, 65534, 65534, 65534), 1,
                     '{sl2_pkg::ST_LOAD_BAD, 0, 0, 0}});
    // singular matrix: slot 1 keeps its old contents
    rows.push_back('{mk_load(1, 1, 1, 1, 1), 1, '{sl2_pkg::ST_LOAD_BAD, 0, 0, 0}});
    rows.push_back('{mk_letter(15, 0, 0, 0), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk_letter(15, 1, 1, 0), 0, '{0, 0, 0, 0}});
    // presentation end without relator end is ignored
    rows.push_back('{mk_letter(1, 0, 0, 1), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk_letter(1, 1, 1, 1), 0, '{0, 0, 0, 0}});
    rows.push_back('{mk_letter(0, 0, 1, 1), 1, '{sl2_pkg::ST_VERDICT, 1, 1, 1}});
    rows.push_back('{mk_letter(15, 0, 1, 0), 1, '{sl2_pkg::ST_VERDICT, 0, 0, 0}});
    rows.push_back('{mk_letter(0, 1, 1, 1), 1, '{sl2_pkg::ST_VERDICT, 1, 0, 1}});
    foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].v);

    run_phase(16'd65521, 1'b1, 260);
    idle_pct = 0;
    run_phase(16'd2, 1'b1, 220);
    idle_pct = 14;
    run_phase(16'd65535, 1'b0, 240);
    run_phase(16'd3, 1'b1, 220);
    run_phase(16'd1, 1'b0, 60);
    run_phase(16'd0, 1'b1, 60);
    run_phase(16'd251, 1'b0, 240);
    run_phase(16'd65521, 1'b0, 260);
    run_phase(16'd7, 1'b1, 220);
    run_phase(16'd65519, 1'b1, 240);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sl2_mod_p_relator_check.f
rtl/sl2_pkg.sv
rtl/sl2_if.sv
rtl/sl2_modmul.sv
rtl/sl2_mod_p_relator_check.sv
verif/sl2_mod_p_relator_check_tb.sv
